// ===== design/smbus_master_with_pec_defines.svh =====
// Assertion macros for the SMBus master checker.
`ifndef SMBUS_MASTER_WITH_PEC_DEFINES_SVH
`define SMBUS_MASTER_WITH_PEC_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define SMB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define SMB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/smb_pkg.sv =====
// Shared types, codes and the PEC step for the SMBus master.
`default_nettype none
package smb_pkg;
  localparam logic [7:0] AckTimeoutReset = 8'd200;
  localparam logic [7:0] PecPoly = 8'h07;
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_DATA  = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START1, PH_START2, PH_TXH, PH_TXL, PH_ACKA, PH_ACKB, PH_POLL,
    PH_STOP1, PH_STOP2, PH_WAIT, PH_RXL, PH_RXH, PH_RAKA, PH_RAKB
  } phase_t;

  typedef enum logic [2:0] {
    SG_ADDR_W, SG_REG, SG_DATA, SG_PEC, SG_ADDR_R, SG_RX_DATA, SG_RX_PEC
  } stage_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       need_data;
    logic       busy_res;
    logic       last;
    logic       ok;
  } out_item_t;

  // Classified command passed from the front part to the sequencer.
  typedef struct packed {
    kind_t      kind;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] data_byte;
    logic       sda_in;
  } cmd_t;

  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ PecPoly) : (c << 1);
    end
    return c;
  endfunction
endpackage
`default_nettype wire

// ===== design/smb_front.sv =====
// Front part: takes input items into a short command queue.
`default_nettype none
module smb_front import smb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t in_item,
  input  wire logic     in_valid,
  output logic          in_ready,
  output cmd_t          cmd,
  output logic          cmd_valid,
  input  wire logic     cmd_ready
);
  cmd_t q [QueueDepth];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready  = (count != 2'(QueueDepth));
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind_t'(in_item.kind), slave_addr: in_item.slave_addr,
                     reg_addr: in_item.reg_addr, byte_count: in_item.byte_count,
                     data_byte: in_item.data_byte, sda_in: in_item.sda_in};
    end
  end
endmodule
`default_nettype wire

// ===== design/smb_back.sv =====
// Back part: bit-level SMBus sequencer with PEC and a registered result.
`default_nettype none
module smb_back import smb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] ack_timeout,
  input  wire cmd_t       cmd,
  input  wire logic       cmd_valid,
  output logic            cmd_ready,
  output out_item_t       out_item,
  output logic            out_valid,
  input  wire logic       out_ready
);
  phase_t     phase, phase_next;
  stage_t     stage, stage_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shifter, shifter_next, pec, pec_next, bytes_left, bytes_left_next;
  logic [7:0] ack_wait, ack_wait_next, held_register, held_register_next;
  logic [6:0] held_slave, held_slave_next;
  logic       is_read, is_read_next, stop_ok, stop_ok_next;
  logic [2:0] line_levels, line_levels_next, slot;
  logic       bit_tx, take;
  logic [8:0] wait_inc;
  out_item_t  res;

  assign cmd_ready = !out_valid || out_ready;
  assign take      = cmd_valid && cmd_ready;
  assign bit_tx    = shifter[3'd7 - bit_index[2:0]];
  assign wait_inc  = {1'b0, ack_wait} + 9'd1;

  always_comb begin
    phase_next = phase; stage_next = stage; bit_index_next = bit_index;
    shifter_next = shifter; pec_next = pec; bytes_left_next = bytes_left;
    ack_wait_next = ack_wait; held_register_next = held_register;
    held_slave_next = held_slave; is_read_next = is_read; stop_ok_next = stop_ok;
    line_levels_next = line_levels;
    slot = line_levels;
    res = '0;
    unique case (cmd.kind)
      KIND_WRITE, KIND_READ: begin
        if (phase == PH_IDLE) begin
          held_slave_next = cmd.slave_addr;
          held_register_next = cmd.reg_addr;
          bytes_left_next = cmd.byte_count;
          is_read_next = (cmd.kind == KIND_READ);
          ack_wait_next = '0;
          stop_ok_next = 1'b0;
          shifter_next = {cmd.slave_addr, 1'b0};
          pec_next = (cmd.kind == KIND_READ) ? 8'd0 : crc_step(8'd0, {cmd.slave_addr, 1'b0});
          stage_next = SG_ADDR_W;
          bit_index_next = '0;
          phase_next = PH_START1;
        end
      end
      KIND_DATA: begin
        if (phase == PH_WAIT) begin
          pec_next = crc_step(pec, cmd.data_byte);
          bytes_left_next = bytes_left - 8'd1;
          shifter_next = cmd.data_byte;
          stage_next = SG_DATA;
          bit_index_next = '0;
          phase_next = PH_TXH;
        end
      end
      default: begin
        unique case (phase)
          PH_START1: begin slot = 3'b111; phase_next = PH_START2; end
          PH_START2: begin slot = 3'b011; bit_index_next = '0; phase_next = PH_TXH; end
          PH_TXH: begin slot = {bit_tx, 2'b11}; phase_next = PH_TXL; end
          PH_TXL: begin
            slot = {bit_tx, 2'b10};
            bit_index_next = bit_index + 4'd1;
            phase_next = (bit_index == 4'd7) ? PH_ACKA : PH_TXH;
          end
          PH_ACKA: begin slot = 3'b100; phase_next = PH_ACKB; end
          PH_ACKB: begin
            slot = 3'b101;
            ack_wait_next = '0;
            if (ack_timeout == 8'd0) begin
              stop_ok_next = 1'b0; phase_next = PH_STOP1;
            end else begin
              phase_next = PH_POLL;
            end
          end
          PH_POLL: begin
            slot = 3'b101;
            if (!cmd.sda_in) begin
              unique case (stage)
                SG_ADDR_W: begin
                  if (!is_read) pec_next = crc_step(pec, held_register);
                  shifter_next = held_register;
                  stage_next = SG_REG;
                  bit_index_next = '0;
                  phase_next = PH_TXH;
                end
                SG_REG, SG_DATA: begin
                  if (is_read && stage == SG_REG) begin
                    shifter_next = {held_slave, 1'b1};
                    stage_next = SG_ADDR_R;
                    phase_next = PH_START1;
                  end else if (bytes_left != 8'd0) begin
                    phase_next = PH_WAIT;
                  end else begin
                    shifter_next = pec;
                    stage_next = SG_PEC;
                    bit_index_next = '0;
                    phase_next = PH_TXH;
                  end
                end
                SG_PEC: begin stop_ok_next = 1'b1; phase_next = PH_STOP1; end
                default: begin
                  stage_next = (bytes_left != 8'd0) ? SG_RX_DATA : SG_RX_PEC;
                  shifter_next = '0;
                  bit_index_next = '0;
                  phase_next = PH_RXL;
                end
              endcase
            end else if (wait_inc >= {1'b0, ack_timeout}) begin
              stop_ok_next = 1'b0; phase_next = PH_STOP1;
            end else begin
              ack_wait_next = wait_inc[7:0];
            end
          end
          PH_STOP1: begin slot = 3'b010; phase_next = PH_STOP2; end
          PH_STOP2: begin
            slot = 3'b111;
            res.last = 1'b1;
            res.ok = stop_ok;
            phase_next = PH_IDLE;
          end
          PH_RXL: begin slot = 3'b100; phase_next = PH_RXH; end
          PH_RXH: begin
            slot = 3'b101;
            shifter_next = {shifter[6:0], cmd.sda_in};
            bit_index_next = bit_index + 4'd1;
            if (bit_index == 4'd7) begin
              if (stage == SG_RX_DATA) begin
                res.read_byte = {shifter[6:0], cmd.sda_in};
                res.read_valid = 1'b1;
              end
              phase_next = PH_RAKA;
            end else begin
              phase_next = PH_RXL;
            end
          end
          PH_RAKA: begin slot = 3'b110; phase_next = PH_RAKB; end
          PH_RAKB: begin
            slot = 3'b111;
            if (stage == SG_RX_DATA) begin
              bytes_left_next = bytes_left - 8'd1;
              if (bytes_left == 8'd1) stage_next = SG_RX_PEC;
              shifter_next = '0;
              bit_index_next = '0;
              phase_next = PH_RXL;
            end else begin
              stop_ok_next = 1'b1; phase_next = PH_STOP1;
            end
          end
          default: ;
        endcase
        line_levels_next = slot;
        if (phase_next == PH_WAIT || (phase_next == PH_RXL && slot[0]) ||
            (res.last && !res.ok)) begin
          line_levels_next = {slot[2:1], 1'b0};
        end
      end
    endcase
    res.scl = slot[0];
    res.sda_drive = slot[1];
    res.sda_level = slot[2];
    res.need_data = (phase_next == PH_WAIT);
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; stage <= SG_ADDR_W; bit_index <= '0; shifter <= '0;
      pec <= '0; bytes_left <= '0; ack_wait <= '0; held_slave <= '0;
      held_register <= '0; is_read <= 1'b0; stop_ok <= 1'b0;
      line_levels <= 3'b010; out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase <= phase_next; stage <= stage_next; bit_index <= bit_index_next;
        shifter <= shifter_next; pec <= pec_next; bytes_left <= bytes_left_next;
        ack_wait <= ack_wait_next; held_slave <= held_slave_next;
        held_register <= held_register_next; is_read <= is_read_next;
        stop_ok <= stop_ok_next; line_levels <= line_levels_next;
      end
      if (cmd_ready) out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_item <= res;
  end
endmodule
`default_nettype wire

// ===== design/smbus_master_with_pec.sv =====
// Top level of the SMBus master with PEC.
// Each input item is one tick slot or one command, and every item returns exactly one result
// item. An item passes through a two-entry command queue and the sequencer's output register,
// and one item can be accepted every cycle while out_ready is high. The input stalls only when
// out_ready stays low long enough for three items to wait inside the block. The ack_timeout
// register is to be written through cfg_we and cfg_data only while no item is in flight;
// the block itself does not enforce this.
`default_nettype none
module smbus_master_with_pec import smb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  input  wire in_item_t   in_item,
  input  wire logic       in_valid,
  output logic            in_ready,
  output out_item_t       out_item,
  output logic            out_valid,
  input  wire logic       out_ready
);
  logic [7:0] ack_timeout;
  cmd_t       cmd;
  logic       cmd_valid, cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= AckTimeoutReset;
    end else if (cfg_we) begin
      ack_timeout <= cfg_data;
    end
  end

  smb_front u_front (
    .clk, .rst, .in_item, .in_valid, .in_ready, .cmd, .cmd_valid, .cmd_ready
  );

  smb_back u_back (
    .clk, .rst, .ack_timeout, .cmd, .cmd_valid, .cmd_ready, .out_item, .out_valid,
    .out_ready
  );
endmodule
`default_nettype wire

// ===== design/smb_checker.sv =====
// Port-level checker for the SMBus master, bound to the top level.
`default_nettype none
`include "smbus_master_with_pec_defines.svh"
module smb_checker import smb_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire out_item_t out_item,
  input wire logic      out_valid,
  input wire logic      out_ready
);
  `SMB_ASSERT_IMP(a_ok_with_last, out_valid && out_item.ok, out_item.last, "ok without last")
  `SMB_ASSERT_IMP(a_last_idle, out_valid && out_item.last, !out_item.busy_res, "last while busy")
  `SMB_ASSERT_IMP(a_need_busy, out_valid && out_item.need_data, out_item.busy_res, "need_data idle")
  `SMB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "out changed")
endmodule
bind smbus_master_with_pec smb_checker u_checker (
  .clk, .rst, .out_item, .out_valid, .out_ready
);
`default_nettype wire
